@@ rtl/lob_pkg.sv @@
// Shared types, constants and helpers for the limit order book.
package lob_pkg;

	localparam int ORDER_SLOTS = 32;
	localparam int IDX_W       = $clog2(ORDER_SLOTS);
	localparam int CNT_W       = $clog2(ORDER_SLOTS + 1);
	localparam int MAX_TRADES  = 31;
	localparam int TRD_W       = 5;
	localparam int IN_DATA_W   = 104;
	localparam int OUT_DATA_W  = 176;
	localparam int OUT_USED_W  = 169;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_CANCEL = 2'd1,
		OP_MODIFY = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_DUP     = 3'd1,
		ST_FAK     = 3'd2,
		ST_UNKNOWN = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] order_id;
		logic        side;
		logic [31:0] limit_price;
		logic [31:0] amount;
		logic        order_kind;
	} req_t;

	// signed order on raw bits: flip the sign bit, compare unsigned
	function automatic logic [31:0] price_key(input logic [31:0] p);
		price_key = p ^ 32'h8000_0000;
	endfunction

endpackage

@@ rtl/limit_order_matching_book.sv @@
// Each request scans the whole book once and then enters a decide state;
//   a modify adds a second scan, an add that is inserted adds one scan per trade plus one
//   final scan, and the status item then goes out through the result register.
//   One request is worked on at a time.
// Reset: arst_n clears all slot valid bits, the arrival counter, the count and queues.
module limit_order_matching_book (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata, from bit 0: order_id[31:0], side, limit_price[31:0], amount[31:0],
	// order_kind, zero pad
	input  logic [lob_pkg::IN_DATA_W-1:0] s_tdata,
	// s_tuser: opcode
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata, from bit 0: buyer_id, buyer_price, seller_id, seller_price,
	// fill_amount, status[2:0], resting_count[5:0], zero pad
	output logic [lob_pkg::OUT_DATA_W-1:0] m_tdata,
	// m_tuser: item_kind (0 trade, 1 status)
	output logic         m_tuser,
	output logic         m_tlast
);

	lob_pkg::req_t req;
	logic          req_valid;
	logic          req_ready;

	// Front: decode requests into a two-entry queue so intake runs up to two requests
	// ahead of matching; hold s_tready low once both entries are taken.
	lob_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready)
	);

	// Back: slot table with a one-slot-per-cycle scan for id, free slot and best prices;
	// trades and the status request go out through a registered result stage.
	lob_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

@@ rtl/lob_front.sv @@
// Request intake: unpack and classify stream requests into a short queue.
module lob_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [lob_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [1:0]       s_tuser,
	output logic             req_valid,
	output lob_pkg::req_t    req,
	input  logic             req_ready
);

	lob_pkg::req_t fifo_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	lob_pkg::req_t in_req;
	logic          push;
	logic          pop;

	always_comb begin
		in_req.op          = lob_pkg::op_t'(s_tuser);
		in_req.order_id    = s_tdata[31:0];
		in_req.side        = s_tdata[32];
		in_req.limit_price = s_tdata[64:33];
		in_req.amount      = s_tdata[96:65];
		in_req.order_kind  = s_tdata[97];
	end

	assign s_tready  = (cnt_q != 2'd2);
	assign req_valid = (cnt_q != 2'd0);
	assign req       = fifo_q[rd_ptr_q];
	assign push      = s_tvalid && s_tready;
	assign pop       = req_valid && req_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ rtl/lob_engine.sv @@
// Book engine: slot table, scan sequencer, matching and result register.
module lob_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  lob_pkg::req_t req,
	output logic          req_ready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [lob_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic          m_tuser,
	output logic          m_tlast
);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_TRADE, S_STATUS
	} state_t;

	typedef enum logic {P_LOOKUP, P_MATCH} pass_t;

	localparam int N = lob_pkg::ORDER_SLOTS;
	localparam int W = lob_pkg::IDX_W;
	localparam int C = lob_pkg::CNT_W;

	state_t state_q;
	pass_t  pass_q;

	logic        slot_valid_q [N];
	logic [31:0] slot_id_q    [N];
	logic        slot_side_q  [N];
	logic [31:0] slot_price_q [N];
	logic [31:0] slot_rem_q   [N];
	logic        slot_kind_q  [N];
	logic [31:0] slot_arr_q   [N];

	lob_pkg::req_t   req_q;
	lob_pkg::op_t    op_q;
	logic            kind_q;
	lob_pkg::status_t status_q;
	logic [31:0]     arrival_q;
	logic [C-1:0]    count_q;
	logic [lob_pkg::TRD_W-1:0] trades_q;
	logic [W-1:0]    idx_q;

	logic            found_q, free_found_q, bid_found_q, ask_found_q;
	logic [W-1:0]    found_idx_q, free_idx_q, bid_idx_q, ask_idx_q;
	logic            found_kind_q, bid_kind_q, ask_kind_q;
	logic [31:0]     bid_id_q, bid_price_q, bid_rem_q, bid_age_q;
	logic [31:0]     ask_id_q, ask_price_q, ask_rem_q, ask_age_q;

	logic                          out_valid_q;
	logic [lob_pkg::OUT_USED_W-1:0] out_data_q;
	logic                          out_kind_q;
	logic                          out_last_q;

	logic        cur_valid, cur_side;
	logic [31:0] cur_price, cur_age;
	logic        hit_id, hit_free, better_bid, better_ask, scan_end;
	logic        fak_fail, crossed, trade_ok, out_free;
	logic        do_accept, do_insert, do_trade, load_status;
	logic [31:0] fill;
	logic        bid_gone, ask_gone;

	always_comb begin
		cur_valid  = slot_valid_q[idx_q];
		cur_side   = slot_side_q[idx_q];
		cur_price  = slot_price_q[idx_q];
		cur_age    = arrival_q - slot_arr_q[idx_q];
		hit_id     = cur_valid && (slot_id_q[idx_q] == req_q.order_id);
		hit_free   = !cur_valid && !free_found_q;
		better_bid = cur_valid && !cur_side && (!bid_found_q ||
			(lob_pkg::price_key(cur_price) > lob_pkg::price_key(bid_price_q)) ||
			((cur_price == bid_price_q) && (cur_age > bid_age_q)));
		better_ask = cur_valid && cur_side && (!ask_found_q ||
			(lob_pkg::price_key(cur_price) < lob_pkg::price_key(ask_price_q)) ||
			((cur_price == ask_price_q) && (cur_age > ask_age_q)));
		scan_end   = (idx_q == W'(N - 1));

		if (!req_q.side) begin
			fak_fail = !ask_found_q || (lob_pkg::price_key(req_q.limit_price) <
				lob_pkg::price_key(ask_price_q));
		end else begin
			fak_fail = !bid_found_q || (lob_pkg::price_key(req_q.limit_price) >
				lob_pkg::price_key(bid_price_q));
		end

		crossed  = lob_pkg::price_key(bid_price_q) >= lob_pkg::price_key(ask_price_q);
		trade_ok = (trades_q < lob_pkg::TRD_W'(lob_pkg::MAX_TRADES)) &&
			bid_found_q && ask_found_q && crossed;
		out_free = !out_valid_q || m_tready;
		fill     = (bid_rem_q < ask_rem_q) ? bid_rem_q : ask_rem_q;
		bid_gone = (bid_rem_q == fill);
		ask_gone = (ask_rem_q == fill);

		do_accept   = (state_q == S_IDLE) && req_valid;
		do_insert   = (state_q == S_DECIDE) && (op_q == lob_pkg::OP_ADD) && !found_q &&
			!(kind_q && fak_fail) && free_found_q;
		do_trade    = (state_q == S_TRADE) && trade_ok && out_free;
		load_status = (state_q == S_STATUS) && out_free;
	end

	assign req_ready = (state_q == S_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(lob_pkg::OUT_DATA_W - lob_pkg::OUT_USED_W){1'b0}}, out_data_q};
	assign m_tuser   = out_kind_q;
	assign m_tlast   = out_last_q;

	// payload: slot fields, scan captures and result data
	always_ff @(posedge clk) begin
		if (do_accept) begin
			req_q <= req;
		end
		if (state_q == S_SCAN) begin
			if (hit_id) begin
				found_idx_q  <= idx_q;
				found_kind_q <= slot_kind_q[idx_q];
			end
			if (hit_free) begin
				free_idx_q <= idx_q;
			end
			if (better_bid) begin
				bid_idx_q   <= idx_q;
				bid_id_q    <= slot_id_q[idx_q];
				bid_price_q <= cur_price;
				bid_rem_q   <= slot_rem_q[idx_q];
				bid_age_q   <= cur_age;
				bid_kind_q  <= slot_kind_q[idx_q];
			end
			if (better_ask) begin
				ask_idx_q   <= idx_q;
				ask_id_q    <= slot_id_q[idx_q];
				ask_price_q <= cur_price;
				ask_rem_q   <= slot_rem_q[idx_q];
				ask_age_q   <= cur_age;
				ask_kind_q  <= slot_kind_q[idx_q];
			end
		end
		if (do_insert) begin
			slot_id_q[free_idx_q]    <= req_q.order_id;
			slot_side_q[free_idx_q]  <= req_q.side;
			slot_price_q[free_idx_q] <= req_q.limit_price;
			slot_rem_q[free_idx_q]   <= req_q.amount;
			slot_kind_q[free_idx_q]  <= kind_q;
			slot_arr_q[free_idx_q]   <= arrival_q;
		end
		if (do_trade) begin
			slot_rem_q[bid_idx_q] <= bid_rem_q - fill;
			slot_rem_q[ask_idx_q] <= ask_rem_q - fill;
			out_data_q <= {6'd0, lob_pkg::ST_DONE, fill, ask_price_q, ask_id_q,
				bid_price_q, bid_id_q};
			out_kind_q <= 1'b0;
			out_last_q <= 1'b0;
		end else if (load_status) begin
			out_data_q <= {6'(count_q), status_q, 160'd0};
			out_kind_q <= 1'b1;
			out_last_q <= 1'b1;
		end
	end

	// control: sequencer, valid bits, counters, result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pass_q       <= P_LOOKUP;
			op_q         <= lob_pkg::OP_NONE;
			kind_q       <= 1'b0;
			status_q     <= lob_pkg::ST_DONE;
			arrival_q    <= '0;
			count_q      <= '0;
			trades_q     <= '0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			bid_found_q  <= 1'b0;
			ask_found_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < N; i++) begin
				slot_valid_q[i] <= 1'b0;
			end
		end else begin
			if (do_trade || load_status) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q         <= req.op;
						kind_q       <= req.order_kind;
						status_q     <= lob_pkg::ST_DONE;
						trades_q     <= '0;
						pass_q       <= P_LOOKUP;
						idx_q        <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						bid_found_q  <= 1'b0;
						ask_found_q  <= 1'b0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit_id)     found_q      <= 1'b1;
					if (hit_free)   free_found_q <= 1'b1;
					if (better_bid) bid_found_q  <= 1'b1;
					if (better_ask) ask_found_q  <= 1'b1;
					if (scan_end) begin
						idx_q   <= '0;
						state_q <= (pass_q == P_LOOKUP) ? S_DECIDE : S_TRADE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DECIDE: begin
					case (op_q)
						lob_pkg::OP_ADD: begin
							if (found_q) begin
								status_q <= lob_pkg::ST_DUP;
								state_q  <= S_STATUS;
							end else if (kind_q && fak_fail) begin
								status_q <= lob_pkg::ST_FAK;
								state_q  <= S_STATUS;
							end else if (!free_found_q) begin
								status_q <= lob_pkg::ST_FULL;
								state_q  <= S_STATUS;
							end else begin
								slot_valid_q[free_idx_q] <= 1'b1;
								arrival_q   <= arrival_q + 32'd1;
								count_q     <= count_q + 1'b1;
								pass_q      <= P_MATCH;
								bid_found_q <= 1'b0;
								ask_found_q <= 1'b0;
								state_q     <= S_SCAN;
							end
						end
						lob_pkg::OP_CANCEL: begin
							if (found_q) begin
								slot_valid_q[found_idx_q] <= 1'b0;
								count_q <= count_q - 1'b1;
							end else begin
								status_q <= lob_pkg::ST_UNKNOWN;
							end
							state_q <= S_STATUS;
						end
						lob_pkg::OP_MODIFY: begin
							if (found_q) begin
								// drop the old order, then rerun as an add with its kind
								slot_valid_q[found_idx_q] <= 1'b0;
								count_q      <= count_q - 1'b1;
								kind_q       <= found_kind_q;
								op_q         <= lob_pkg::OP_ADD;
								found_q      <= 1'b0;
								free_found_q <= 1'b0;
								bid_found_q  <= 1'b0;
								ask_found_q  <= 1'b0;
								state_q      <= S_SCAN;
							end else begin
								status_q <= lob_pkg::ST_UNKNOWN;
								state_q  <= S_STATUS;
							end
						end
						default: begin
							state_q <= S_STATUS;
						end
					endcase
				end
				S_TRADE: begin
					if (trade_ok) begin
						if (out_free) begin
							if (bid_gone) slot_valid_q[bid_idx_q] <= 1'b0;
							if (ask_gone) slot_valid_q[ask_idx_q] <= 1'b0;
							count_q     <= count_q - C'(bid_gone) - C'(ask_gone);
							trades_q    <= trades_q + 1'b1;
							bid_found_q <= 1'b0;
							ask_found_q <= 1'b0;
							state_q     <= S_SCAN;
						end
					end else begin
						// kill fill-and-kill orders left at the front of either side
						if (bid_found_q && bid_kind_q) slot_valid_q[bid_idx_q] <= 1'b0;
						if (ask_found_q && ask_kind_q) slot_valid_q[ask_idx_q] <= 1'b0;
						count_q <= count_q - C'(bid_found_q && bid_kind_q)
							- C'(ask_found_q && ask_kind_q);
						state_q <= S_STATUS;
					end
				end
				S_STATUS: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
